### sv/sat_pkg.sv
package sat_pkg;

    // Storage depth and derived widths
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 4;
    localparam int CAP_W       = 5;
    localparam int OCNT_W      = 5;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RESET   = 16;
    localparam int STEP_W      = 4;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register index of capacity_limit
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key_value;
        logic [POS_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]  read_value;
        logic [1:0]        status;
        logic [OCNT_W-1:0] entry_count;
    } rsp_t;

    // Branch conditions of the control program
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IS_INS,
        C_IS_REM,
        C_IS_RD,
        C_FULL,
        C_IDX_ZERO,
        C_KEY_LT,
        C_LAST,
        C_RANGE
    } cond_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX_DEC,
        RD_IDX_INC,
        RD_POS
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_RDATA,
        WR_BUBBLE
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_COUNT,
        IDX_LOAD_POS,
        IDX_DEC_IF_LT,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        cond_t             cond;
        logic [STEP_W-1:0] target;
        rd_sel_t           rd;
        wr_sel_t           wr;
        idx_op_t           idx_op;
        cnt_op_t           cnt_op;
        logic              fin;
        status_t           st;
        logic              rd_out;
    } ctl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic is_ins;
        logic is_rem;
        logic is_rd;
        logic full;
        logic idx_zero;
        logic key_lt;
        logic last;
        logic range;
    } flags_t;

    // Control program
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '{cond: C_NEVER, target: '0, rd: RD_NONE, wr: WR_NONE, idx_op: IDX_HOLD,
              cnt_op: CNT_HOLD, fin: 1'b0, st: ST_OK, rd_out: 1'b0};
        unique case (step)
            // dispatch on request kind
            4'd0: begin
                w.cond = C_IS_INS; w.target = 4'd4;
            end
            4'd1: begin
                w.cond = C_IS_REM; w.target = 4'd8;
            end
            4'd2: begin
                w.cond = C_IS_RD; w.target = 4'd12;
            end
            4'd3: begin
                w.fin = 1'b1;
            end
            // insert: start at the tail
            4'd4: begin
                w.cond = C_FULL; w.target = 4'd15; w.idx_op = IDX_LOAD_COUNT;
            end
            4'd5: begin
                w.cond = C_IDX_ZERO; w.target = 4'd7; w.rd = RD_IDX_DEC;
            end
            // move the lower neighbor up while the key is smaller
            4'd6: begin
                w.cond = C_KEY_LT; w.target = 4'd5; w.wr = WR_BUBBLE;
                w.idx_op = IDX_DEC_IF_LT;
            end
            4'd7: begin
                w.wr = WR_KEY; w.cnt_op = CNT_INC; w.fin = 1'b1;
            end
            // remove: close the gap from position upward
            4'd8: begin
                w.cond = C_RANGE; w.target = 4'd14; w.idx_op = IDX_LOAD_POS;
            end
            4'd9: begin
                w.cond = C_LAST; w.target = 4'd11; w.rd = RD_IDX_INC;
            end
            4'd10: begin
                w.cond = C_ALWAYS; w.target = 4'd9; w.wr = WR_RDATA; w.idx_op = IDX_INC;
            end
            4'd11: begin
                w.cnt_op = CNT_DEC; w.fin = 1'b1;
            end
            // read
            4'd12: begin
                w.cond = C_RANGE; w.target = 4'd14; w.rd = RD_POS;
            end
            4'd13: begin
                w.fin = 1'b1; w.rd_out = 1'b1;
            end
            4'd14: begin
                w.fin = 1'b1; w.st = ST_RANGE;
            end
            4'd15: begin
                w.fin = 1'b1; w.st = ST_FULL;
            end
            default: begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### sv/sat_seq.sv
module sat_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            hold,
    input  sat_pkg::flags_t flags,
    output sat_pkg::ctl_t   ctl,
    output logic            exec,
    output logic            busy
);
    import sat_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              taken;

    assign ctl  = ucode(step_reg);
    assign busy = busy_reg;
    // hold the finishing step while the result register is still occupied and stalled
    assign exec = busy_reg && !(ctl.fin && hold);

    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_IS_INS:   taken = flags.is_ins;
            C_IS_REM:   taken = flags.is_rem;
            C_IS_RD:    taken = flags.is_rd;
            C_FULL:     taken = flags.full;
            C_IDX_ZERO: taken = flags.idx_zero;
            C_KEY_LT:   taken = flags.key_lt;
            C_LAST:     taken = flags.last;
            C_RANGE:    taken = flags.range;
            default:    taken = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        priority if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (!exec)
        begin
            step_next = step_reg;
        end
        else if (ctl.fin)
        begin
            busy_next = 1'b0;
            step_next = '0;
        end
        else if (taken)
        begin
            step_next = ctl.target;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### sv/sat_dp.sv
module sat_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  sat_pkg::req_t               req,
    input  logic [sat_pkg::CAP_W-1:0]   capacity,
    input  sat_pkg::ctl_t               ctl,
    input  logic                        exec,
    output sat_pkg::flags_t             flags,
    output logic [sat_pkg::KEY_W-1:0]   rdata,
    output logic [sat_pkg::CNT_W-1:0]   count,
    output logic [sat_pkg::CNT_W-1:0]   count_upd
);
    import sat_pkg::*;

    logic [KEY_W-1:0] entries [MAX_ENTRIES];

    logic [1:0]       kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [KEY_W-1:0] rdata_reg;

    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W:0]   idx_plus;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic [KEY_W-1:0] wr_data;
    logic             wr_en;
    logic             key_lt;

    assign pos_ext  = CNT_W'(pos_reg);
    assign idx_plus = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(1);
    assign key_lt   = key_reg < rdata_reg;

    assign flags.is_ins   = kind_reg == REQ_INSERT;
    assign flags.is_rem   = kind_reg == REQ_REMOVE;
    assign flags.is_rd    = kind_reg == REQ_READ;
    // effective limit is the smaller of the register and the storage depth
    assign flags.full     = (count_reg >= CNT_W'(MAX_ENTRIES))
                            || (CMP_W'(count_reg) >= CMP_W'(capacity));
    assign flags.idx_zero = idx_reg == '0;
    assign flags.key_lt   = key_lt;
    assign flags.last     = idx_plus >= (CNT_W+1)'(count_reg);
    assign flags.range    = pos_ext >= count_reg;

    assign rdata     = rdata_reg;
    assign count     = count_reg;
    assign count_upd = count_next;

    always_comb
    begin
        unique case (ctl.rd)
            RD_IDX_DEC: rd_addr = idx_reg[IDX_W-1:0] - IDX_W'(1);
            RD_IDX_INC: rd_addr = idx_reg[IDX_W-1:0] + IDX_W'(1);
            RD_POS:     rd_addr = pos_reg[IDX_W-1:0];
            default:    rd_addr = idx_reg[IDX_W-1:0];
        endcase
        rd_en = exec && (ctl.rd != RD_NONE);
    end

    always_comb
    begin
        unique case (ctl.wr)
            WR_KEY:    wr_data = key_reg;
            WR_RDATA:  wr_data = rdata_reg;
            WR_BUBBLE: wr_data = key_lt ? rdata_reg : key_reg;
            default:   wr_data = key_reg;
        endcase
        wr_en = exec && (ctl.wr != WR_NONE);
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (exec)
        begin
            unique case (ctl.idx_op)
                IDX_LOAD_COUNT: idx_next = count_reg;
                IDX_LOAD_POS:   idx_next = pos_ext;
                IDX_DEC_IF_LT:  idx_next = key_lt ? idx_reg - CNT_W'(1) : idx_reg;
                IDX_INC:        idx_next = idx_reg + CNT_W'(1);
                default:        idx_next = idx_reg;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (exec)
        begin
            unique case (ctl.cnt_op)
                CNT_INC: count_next = count_reg + CNT_W'(1);
                CNT_DEC: count_next = count_reg - CNT_W'(1);
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries[idx_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= entries[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg <= req.req_type;
            key_reg  <= req.key_value;
            pos_reg  <= req.position;
        end
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### sv/sorted_array_table.sv
// Sorted key table: holds up to capacity_limit (capped at 16) unsigned 32-bit
// keys in ascending order. Each request beat (insert, remove at position,
// read at position) yields one response beat with status, read value and the
// entry count after the request. Requests run one at a time on a microcoded
// sequencer over a single-port key memory with registered read data, so the
// step count is set by one memory read per element visited: insert walks
// down from the tail past every larger key, remove shifts down each entry
// above the removed one, and read, refused or unused requests visit at most
// one element. The next request beat is taken in the cycle after the response
// is loaded. A new request is taken while the previous response still waits.
// capacity_limit sits at byte address 0 and resets to 16; write it only while
// the table is idle.
module sorted_array_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sat_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sat_pkg::rsp_t                 rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sat_pkg::PADDR_W-1:0]   paddr,
    input  logic [sat_pkg::PDATA_W-1:0]   pwdata,
    output logic [sat_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import sat_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;

    logic             start;
    logic             hold;
    logic             busy;
    logic             exec;
    ctl_t             ctl;
    flags_t           flags;
    logic [KEY_W-1:0] rdata;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_upd;
    logic             out_load;

    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_wr && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign req_stall = busy;
    assign start     = req_valid && !req_stall;
    assign hold      = rsp_valid_reg && rsp_stall;

    sat_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hold  (hold),
        .flags (flags),
        .ctl   (ctl),
        .exec  (exec),
        .busy  (busy)
    );

    sat_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .capacity  (cap_reg),
        .ctl       (ctl),
        .exec      (exec),
        .flags     (flags),
        .rdata     (rdata),
        .count     (count),
        .count_upd (count_upd)
    );

    assign out_load = exec && ctl.fin;

    always_comb
    begin
        rsp_next.read_value  = ctl.rd_out ? rdata : '0;
        rsp_next.status      = ctl.st;
        rsp_next.entry_count = OCNT_W'(count_upd);
        priority if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above storage depth");

    a_count_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count) |-> $past(out_load))
        else $error("entry count changed outside a finishing step");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("accepted request did not start the sequencer");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (rsp_valid && rsp.entry_count == OCNT_W'(count)))
        else $error("response count disagrees with table count");
`endif

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 50;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * int'(REG_CAPACITY));

    // Mirror of the sorted table; predicts one response beat per request beat
    class sorted_table_scoreboard;
        logic [KEY_W-1:0] keys [MAX_ENTRIES];
        int unsigned      stored;
        logic [CAP_W-1:0] capacity;
        rsp_t             pending_replies [$];
        int               errors;

        function new();
            stored   = 0;
            capacity = CAP_W'(CAP_RESET);
            errors   = 0;
        endfunction

        function void set_capacity(logic [PDATA_W-1:0] value);
            capacity = value[CAP_W-1:0];
        endfunction

        function int unsigned limit();
            return (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void note_request(req_t r);
            rsp_t             exp_rsp;
            status_t          st;
            logic [KEY_W-1:0] rd;
            logic [KEY_W-1:0] tmp;
            int unsigned      i;
            st = ST_OK;
            rd = '0;
            case (req_kind_t'(r.req_type))
                REQ_INSERT:
                begin
                    if (stored >= limit())
                        st = ST_FULL;
                    else
                    begin
                        // place at the tail, then bubble down past larger keys
                        i = stored;
                        keys[i] = r.key_value;
                        stored++;
                        while (i > 0 && keys[i] < keys[i-1])
                        begin
                            tmp       = keys[i];
                            keys[i]   = keys[i-1];
                            keys[i-1] = tmp;
                            i--;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (r.position >= stored)
                        st = ST_RANGE;
                    else
                    begin
                        stored--;
                        for (i = r.position; i < stored; i++)
                            keys[i] = keys[i+1];
                    end
                end
                REQ_READ:
                begin
                    if (r.position >= stored)
                        st = ST_RANGE;
                    else
                        rd = keys[r.position];
                end
                default:
                begin
                end
            endcase
            exp_rsp.read_value  = rd;
            exp_rsp.status      = st;
            exp_rsp.entry_count = OCNT_W'(stored);
            pending_replies.push_back(exp_rsp);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: response beat with nothing expected: %h", $time, got);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, got.read_value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_t                req       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    sorted_table_scoreboard sb;
    bit                     calm = 1'b0;
    int                     idle_cycles = 0;

    sorted_array_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic req_t build_request(req_kind_t kind, logic [KEY_W-1:0] key,
                                           logic [POS_W-1:0] pos);
        req_t r;
        r.req_type  = kind;
        r.key_value = key;
        r.position  = pos;
        return r;
    endfunction

    function automatic req_t random_request(int ins_pct);
        req_t             r;
        int               pick;
        int               sel;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        req_kind_t        kind;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)
            kind = REQ_INSERT;
        else if (pick < ins_pct + (100 - ins_pct) * 2 / 5)
            kind = REQ_REMOVE;
        else if (pick < 95)
            kind = REQ_READ;
        else
            kind = REQ_NONE;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            key = $urandom();
        else if (sel < 8)
            key = $urandom_range(0, 7);
        else if (sel == 8)
            key = $urandom_range(0, 1) ? '1 : '0;
        else if (sb.stored > 0)
            key = sb.keys[$urandom_range(0, sb.stored - 1)];
        else
            key = $urandom();
        // mostly aim at live entries, sometimes anywhere
        if (sb.stored > 0 && $urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(0, sb.stored - 1));
        else
            pos = POS_W'($urandom_range(0, 15));
        r = build_request(kind, key, pos);
        return r;
    endfunction

    task automatic send_request(req_t r);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // drop valid and wait for every reply plus the sequencer's tail
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        logic [PDATA_W-1:0] data;
        data = ($urandom() & ~PDATA_W'(32'h1F)) | PDATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_capacity(data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // response side: hold stall for a random count after each beat
    initial
    begin
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                sb.check_response(rsp);
                hold = draw_gap();
            end
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sorted_array_table test failed");
            $finish;
        end
    end

    initial
    begin
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        int               phase_ins [NUM_PHASES];
        int               p;
        int               n;
        sb = new();
        phase_cap = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd10, 5'd16};
        phase_ins = '{55, 45, 50, 60, 45, 50, 50, 35};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extreme and equal keys, reads, removes
        send_request(build_request(REQ_READ, '0, 4'd0));
        send_request(build_request(REQ_REMOVE, '0, 4'd0));
        send_request(build_request(REQ_NONE, '1, 4'd15));
        send_request(build_request(REQ_INSERT, 32'hFFFF_FFFF, 4'd15));
        send_request(build_request(REQ_INSERT, 32'h0000_0000, 4'd0));
        send_request(build_request(REQ_INSERT, 32'h0000_0000, 4'd5));
        send_request(build_request(REQ_INSERT, 32'h8000_0000, 4'd0));
        send_request(build_request(REQ_INSERT, 32'h7FFF_FFFF, 4'd0));
        send_request(build_request(REQ_INSERT, 32'hFFFF_FFFF, 4'd0));
        for (n = 0; n < 6; n++)
            send_request(build_request(REQ_READ, '1, POS_W'(n)));
        send_request(build_request(REQ_READ, '0, 4'd15));
        send_request(build_request(REQ_REMOVE, '0, 4'd15));
        send_request(build_request(REQ_REMOVE, '0, 4'd2));
        send_request(build_request(REQ_REMOVE, '0, 4'd0));
        send_request(build_request(REQ_REMOVE, '0, 4'd2));
        send_request(build_request(REQ_READ, '0, 4'd2));
        send_request(build_request(REQ_NONE, '0, 4'd0));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_capacity(phase_cap[p]);
            calm = (p % 3 == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(phase_ins[p]));
        end
        calm = 1'b0;

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sorted_array_table test passed");
        else
            $display("sorted_array_table test failed");
        $finish;
    end

endmodule
